[hw/rtl/plane_collision_response_assert.svh]
// Assertion macros shared by the plane collision response RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef PLANE_COLLISION_RESPONSE_ASSERT_SVH
`define PLANE_COLLISION_RESPONSE_ASSERT_SVH

// Condition must never hold while out of reset.
`define PCR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent on the following clock.
`define PCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pcr_pkg.sv]
// Package for the plane collision response block: widths, config and job types.
// Used by pcr_front, pcr_fifo, pcr_back and plane_collision_response.
`default_nettype none
package pcr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = 32;
    localparam int N_W        = 18;
    localparam int MRG_W      = 31;
    localparam int KR_W       = 18;
    localparam int CFG_W      = 32;
    localparam int IDX_W      = 3;
    localparam int DIF_W      = POS_W + 1;
    localparam int PRD_W      = DIF_W + N_W;
    localparam int DOT_W      = PRD_W + 1;
    localparam int S_W        = DOT_W - FRAC_BITS;
    localparam int VN_W       = S_W + N_W - FRAC_BITS;
    localparam int T_W        = FRAC_BITS + 1;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_NORMAL_X,
        CFG_NORMAL_Y,
        CFG_MARGIN,
        CFG_RESTITUTION
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FRC_NONE,
        FRC_ZERO,
        FRC_ONE
    } t_force;

    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic signed [N_W-1:0]   normal_x;
        logic signed [N_W-1:0]   normal_y;
        logic [MRG_W-1:0]        margin;
        logic [KR_W-1:0]         restitution;
    } t_cfg;

    // One classified particle request between front and back.
    typedef struct packed {
        logic                    hit;
        logic                    back;
        logic signed [POS_W-1:0] vx;
        logic signed [POS_W-1:0] vy;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] qx;
        logic signed [POS_W-1:0] qy;
        logic signed [S_W-1:0]   s;
        logic signed [DOT_W-1:0] num;
        logic signed [DOT_W-1:0] den;
        logic signed [DIF_W-1:0] dqx;
        logic signed [DIF_W-1:0] dqy;
    } t_job;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi) begin
            sat_pos = hi[POS_W-1:0];
        end else if (x < lo) begin
            sat_pos = lo[POS_W-1:0];
        end else begin
            sat_pos = x[POS_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

[hw/rtl/pcr_front.sv]
// Front end: accepts particle requests, forms the plane dot products, classifies.
// Depends on pcr_pkg. Credit counter keeps pcr_fifo from overflowing.
`default_nettype none
module pcr_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pcr_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [pcr_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [pcr_pkg::POS_W-1:0] i_pos_y,
    input  wire logic signed [pcr_pkg::POS_W-1:0] i_prev_x,
    input  wire logic signed [pcr_pkg::POS_W-1:0] i_prev_y,
    input  wire logic signed [pcr_pkg::POS_W-1:0] i_vel_x,
    input  wire logic signed [pcr_pkg::POS_W-1:0] i_vel_y,
    input  wire logic                          i_pop,
    output logic                               o_push,
    output pcr_pkg::t_job                      o_job
);

    logic                                 accept;
    logic [pcr_pkg::FIFO_CW-1:0]          r_occ;
    logic [pcr_pkg::FIFO_CW-1:0]          n_occ;
    logic                                 r_v1, r_v2, r_v3;
    pcr_pkg::t_job                        n_j1, r_j1, r_j2, r_j3;
    logic signed [pcr_pkg::DIF_W-1:0]     n_dpx, n_dpy, n_oqx, n_oqy;
    logic signed [pcr_pkg::DIF_W-1:0]     r_dpx, r_dpy, r_oqx, r_oqy;
    logic signed [pcr_pkg::PRD_W-1:0]     r_pdx, r_pdy, r_pvx, r_pvy;
    logic signed [pcr_pkg::PRD_W-1:0]     r_pox, r_poy, r_pqx, r_pqy;
    logic signed [pcr_pkg::DOT_W-1:0]     r_dist, r_vdot, r_num, r_den;
    logic signed [pcr_pkg::DOT_W-1:0]     eps;

    // occupancy counts requests in flight here plus those queued
    assign o_ready = r_occ < pcr_pkg::FIFO_CW'(pcr_pkg::FIFO_DEPTH);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_occ = r_occ + pcr_pkg::FIFO_CW'(accept) - pcr_pkg::FIFO_CW'(i_pop);
    end

    always_comb begin
        n_j1     = '0;
        n_j1.vx  = i_vel_x;
        n_j1.vy  = i_vel_y;
        n_j1.px  = i_pos_x;
        n_j1.py  = i_pos_y;
        n_j1.qx  = i_prev_x;
        n_j1.qy  = i_prev_y;
        n_j1.dqx = {i_pos_x[pcr_pkg::POS_W-1], i_pos_x} - {i_prev_x[pcr_pkg::POS_W-1], i_prev_x};
        n_j1.dqy = {i_pos_y[pcr_pkg::POS_W-1], i_pos_y} - {i_prev_y[pcr_pkg::POS_W-1], i_prev_y};
        n_dpx = {i_pos_x[pcr_pkg::POS_W-1], i_pos_x}
              - {i_cfg.origin_x[pcr_pkg::POS_W-1], i_cfg.origin_x};
        n_dpy = {i_pos_y[pcr_pkg::POS_W-1], i_pos_y}
              - {i_cfg.origin_y[pcr_pkg::POS_W-1], i_cfg.origin_y};
        n_oqx = {i_cfg.origin_x[pcr_pkg::POS_W-1], i_cfg.origin_x}
              - {i_prev_x[pcr_pkg::POS_W-1], i_prev_x};
        n_oqy = {i_cfg.origin_y[pcr_pkg::POS_W-1], i_cfg.origin_y}
              - {i_prev_y[pcr_pkg::POS_W-1], i_prev_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_occ <= n_occ;
            r_v1  <= accept;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
        end
    end

    // datapath: differences, products, dot sums
    always_ff @(posedge i_clk) begin
        r_j1   <= n_j1;
        r_dpx  <= n_dpx;
        r_dpy  <= n_dpy;
        r_oqx  <= n_oqx;
        r_oqy  <= n_oqy;
        r_j2   <= r_j1;
        r_pdx  <= r_dpx * i_cfg.normal_x;
        r_pdy  <= r_dpy * i_cfg.normal_y;
        r_pvx  <= r_j1.vx * i_cfg.normal_x;
        r_pvy  <= r_j1.vy * i_cfg.normal_y;
        r_pox  <= r_oqx * i_cfg.normal_x;
        r_poy  <= r_oqy * i_cfg.normal_y;
        r_pqx  <= r_j1.dqx * i_cfg.normal_x;
        r_pqy  <= r_j1.dqy * i_cfg.normal_y;
        r_j3   <= r_j2;
        r_dist <= r_pdx + r_pdy;
        r_vdot <= r_pvx + r_pvy;
        r_num  <= r_pox + r_poy;
        r_den  <= r_pqx + r_pqy;
    end

    assign eps = $signed({{(pcr_pkg::DOT_W - pcr_pkg::MRG_W - pcr_pkg::FRAC_BITS){1'b0}},
                          i_cfg.margin, {pcr_pkg::FRAC_BITS{1'b0}}});

    always_comb begin
        o_job      = r_j3;
        o_job.hit  = (r_dist < eps) && r_vdot[pcr_pkg::DOT_W-1];
        o_job.back = o_job.hit && (r_dist <= $signed({pcr_pkg::DOT_W{1'b0}}));
        o_job.s    = $signed(r_vdot[pcr_pkg::DOT_W-1:pcr_pkg::FRAC_BITS]);
        o_job.num  = r_num;
        o_job.den  = r_den;
    end

    assign o_push = r_v3;

endmodule
`default_nettype wire

[hw/rtl/pcr_fifo.sv]
// Short request queue between front and back ends, register based.
// Depends on pcr_pkg and plane_collision_response_assert.svh.
`default_nettype none
`include "plane_collision_response_assert.svh"
module pcr_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pcr_pkg::t_job i_data,
    input  wire logic          i_pop,
    output logic               o_nempty,
    output pcr_pkg::t_job      o_data
);

    pcr_pkg::t_job                r_mem [pcr_pkg::FIFO_DEPTH];
    logic [pcr_pkg::FIFO_AW-1:0]  r_wr, r_rd;
    logic [pcr_pkg::FIFO_CW-1:0]  r_cnt;

    assign o_nempty = r_cnt != '0;
    assign o_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + pcr_pkg::FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + pcr_pkg::FIFO_AW'(1);
            end
            r_cnt <= r_cnt + pcr_pkg::FIFO_CW'(i_push) - pcr_pkg::FIFO_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `PCR_ASSERT_NEVER(a_no_overflow, i_push && !i_pop && r_cnt == pcr_pkg::FIFO_CW'(pcr_pkg::FIFO_DEPTH), "queue overflow")
    `PCR_ASSERT_NEVER(a_no_underflow, i_pop && r_cnt == '0, "queue underflow")
    `PCR_ASSERT_NEXT(a_cnt_up, i_push && !i_pop, r_cnt == $past(r_cnt) + pcr_pkg::FIFO_CW'(1), "count lost a push")

endmodule
`default_nettype wire

[hw/rtl/pcr_back.sv]
// Back end: velocity response, rewind fraction divider, rewound position.
// Depends on pcr_pkg. Whole pipeline advances when the output register frees.
`default_nettype none
module pcr_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire pcr_pkg::t_cfg                    i_cfg,
    input  wire logic                             i_job_valid,
    input  wire pcr_pkg::t_job                    i_job,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_collided,
    output logic                                  o_rewound,
    output logic signed [pcr_pkg::POS_W-1:0]      o_new_vel_x,
    output logic signed [pcr_pkg::POS_W-1:0]      o_new_vel_y,
    output logic [pcr_pkg::T_W-1:0]               o_rewind_fraction,
    output logic signed [pcr_pkg::POS_W-1:0]      o_new_pos_x,
    output logic signed [pcr_pkg::POS_W-1:0]      o_new_pos_y
);

    localparam int F    = pcr_pkg::FRAC_BITS;
    localparam int KV_W = pcr_pkg::VN_W + pcr_pkg::KR_W + 1;
    localparam int DV_W = KV_W - F + 1;
    localparam int TP_W = pcr_pkg::T_W + pcr_pkg::DIF_W + 1;

    typedef struct packed {
        logic                                hit;
        logic                                back;
        logic signed [pcr_pkg::POS_W-1:0]    px;
        logic signed [pcr_pkg::POS_W-1:0]    py;
        logic signed [pcr_pkg::POS_W-1:0]    qx;
        logic signed [pcr_pkg::POS_W-1:0]    qy;
        logic signed [pcr_pkg::DIF_W-1:0]    dqx;
        logic signed [pcr_pkg::DIF_W-1:0]    dqy;
        logic signed [pcr_pkg::POS_W-1:0]    vx;
        logic signed [pcr_pkg::POS_W-1:0]    vy;
        logic signed [pcr_pkg::VN_W-1:0]     vnx;
        logic signed [pcr_pkg::VN_W-1:0]     vny;
        logic [pcr_pkg::DOT_W-1:0]           an;
        logic [pcr_pkg::DOT_W-1:0]           ad;
        pcr_pkg::t_force                     frc;
        logic signed [pcr_pkg::VN_W:0]       vtx;
        logic signed [pcr_pkg::VN_W:0]       vty;
        logic signed [KV_W-1:0]              kvx;
        logic signed [KV_W-1:0]              kvy;
        logic signed [pcr_pkg::POS_W-1:0]    nvx;
        logic signed [pcr_pkg::POS_W-1:0]    nvy;
        logic [pcr_pkg::DOT_W-1:0]           rem;
        logic [F-1:0]                        quo;
        logic [pcr_pkg::T_W-1:0]             t;
        logic signed [TP_W-1:0]              tpx;
        logic signed [TP_W-1:0]              tpy;
    } t_bs;

    // one restoring division step: one quotient bit
    function automatic t_bs div_step(input t_bs x);
        t_bs                       y;
        logic [pcr_pkg::DOT_W:0]   r2;
        logic [pcr_pkg::DOT_W:0]   dif;
        logic                      ge;
        y   = x;
        r2  = {x.rem, 1'b0};
        dif = r2 - {1'b0, x.ad};
        ge  = r2 >= {1'b0, x.ad};
        y.rem = ge ? dif[pcr_pkg::DOT_W-1:0] : r2[pcr_pkg::DOT_W-1:0];
        y.quo = {x.quo[F-2:0], ge};
        return y;
    endfunction

    logic                              adv;
    logic                              r_va, r_vb, r_vc, r_ve;
    logic                              r_vd [F+1];
    pcr_pkg::t_job                     r_ja;
    t_bs                               n_sb, r_sb, n_sc, r_sc, n_sd0, n_se, r_se;
    t_bs                               r_sd [F+1];
    logic signed [pcr_pkg::S_W+pcr_pkg::N_W-1:0] svx, svy;
    logic signed [DV_W-1:0]            dvx, dvy;
    logic signed [63:0]                wpx, wpy;
    logic                              r_ov, r_col, r_rew;
    logic signed [pcr_pkg::POS_W-1:0]  r_nvx, r_nvy, r_npx, r_npy;
    logic [pcr_pkg::T_W-1:0]           r_t;

    assign adv   = !r_ov || i_ready;
    assign o_pop = adv && i_job_valid;

    // stage B: normal velocity, divider operand magnitudes and special cases
    always_comb begin
        n_sb      = '0;
        svx       = r_ja.s * i_cfg.normal_x;
        svy       = r_ja.s * i_cfg.normal_y;
        n_sb.hit  = r_ja.hit;
        n_sb.back = r_ja.back;
        n_sb.px   = r_ja.px;
        n_sb.py   = r_ja.py;
        n_sb.qx   = r_ja.qx;
        n_sb.qy   = r_ja.qy;
        n_sb.dqx  = r_ja.dqx;
        n_sb.dqy  = r_ja.dqy;
        n_sb.vx   = r_ja.vx;
        n_sb.vy   = r_ja.vy;
        n_sb.vnx  = $signed(svx[pcr_pkg::S_W+pcr_pkg::N_W-1:F]);
        n_sb.vny  = $signed(svy[pcr_pkg::S_W+pcr_pkg::N_W-1:F]);
        n_sb.an   = r_ja.num[pcr_pkg::DOT_W-1] ? pcr_pkg::DOT_W'(-r_ja.num) : r_ja.num;
        n_sb.ad   = r_ja.den[pcr_pkg::DOT_W-1] ? pcr_pkg::DOT_W'(-r_ja.den) : r_ja.den;
        priority if (r_ja.den == '0) begin
            n_sb.frc = pcr_pkg::FRC_ONE;
        end else if (r_ja.num == '0
                     || r_ja.num[pcr_pkg::DOT_W-1] != r_ja.den[pcr_pkg::DOT_W-1]) begin
            n_sb.frc = pcr_pkg::FRC_ZERO;
        end else begin
            n_sb.frc = pcr_pkg::FRC_NONE;
        end
    end

    // stage C: tangential part, restitution product, divider seed, ratio >= 1 check
    always_comb begin
        n_sc     = r_sb;
        n_sc.vtx = r_sb.vx - r_sb.vnx;
        n_sc.vty = r_sb.vy - r_sb.vny;
        n_sc.kvx = $signed({1'b0, i_cfg.restitution}) * r_sb.vnx;
        n_sc.kvy = $signed({1'b0, i_cfg.restitution}) * r_sb.vny;
        n_sc.rem = r_sb.an;
        n_sc.quo = '0;
        if (r_sb.frc == pcr_pkg::FRC_NONE && r_sb.an >= r_sb.ad) begin
            n_sc.frc = pcr_pkg::FRC_ONE;
        end
    end

    // stage D0: final velocity
    always_comb begin
        n_sd0     = r_sc;
        dvx       = r_sc.vtx - $signed(r_sc.kvx[KV_W-1:F]);
        dvy       = r_sc.vty - $signed(r_sc.kvy[KV_W-1:F]);
        n_sd0.nvx = r_sc.hit ? pcr_pkg::sat_pos(64'(dvx)) : r_sc.vx;
        n_sd0.nvy = r_sc.hit ? pcr_pkg::sat_pos(64'(dvy)) : r_sc.vy;
    end

    // stage E: fraction select and position products
    always_comb begin
        n_se = r_sd[F];
        priority if (!n_se.back || n_se.frc == pcr_pkg::FRC_ONE) begin
            n_se.t = pcr_pkg::T_ONE;
        end else if (n_se.frc == pcr_pkg::FRC_ZERO) begin
            n_se.t = '0;
        end else begin
            n_se.t = {1'b0, n_se.quo};
        end
        n_se.tpx = $signed({1'b0, n_se.t}) * n_se.dqx;
        n_se.tpy = $signed({1'b0, n_se.t}) * n_se.dqy;
    end

    assign wpx = 64'(r_se.qx) + 64'($signed(r_se.tpx[TP_W-1:F]));
    assign wpy = 64'(r_se.qy) + 64'($signed(r_se.tpy[TP_W-1:F]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_ve <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k <= F; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (adv) begin
            r_va    <= i_job_valid;
            r_vb    <= r_va;
            r_vc    <= r_vb;
            r_vd[0] <= r_vc;
            for (int k = 0; k < F; k++) begin
                r_vd[k+1] <= r_vd[k];
            end
            r_ve <= r_vd[F];
            r_ov <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ja    <= i_job;
            r_sb    <= n_sb;
            r_sc    <= n_sc;
            r_sd[0] <= n_sd0;
            for (int k = 0; k < F; k++) begin
                r_sd[k+1] <= div_step(r_sd[k]);
            end
            r_se  <= n_se;
            r_col <= r_se.hit;
            r_rew <= r_se.back;
            r_nvx <= r_se.nvx;
            r_nvy <= r_se.nvy;
            r_t   <= r_se.t;
            r_npx <= r_se.back ? pcr_pkg::sat_pos(wpx) : r_se.px;
            r_npy <= r_se.back ? pcr_pkg::sat_pos(wpy) : r_se.py;
        end
    end

    assign o_valid           = r_ov;
    assign o_collided        = r_col;
    assign o_rewound         = r_rew;
    assign o_new_vel_x       = r_nvx;
    assign o_new_vel_y       = r_nvy;
    assign o_rewind_fraction = r_t;
    assign o_new_pos_x       = r_npx;
    assign o_new_pos_y       = r_npy;

endmodule
`default_nettype wire

[hw/rtl/plane_collision_response.sv]
// Plane collision response top level: config registers, front, queue, back.
// Depends on pcr_pkg, pcr_front, pcr_fifo and pcr_back.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one particle request per cycle:
//   position, previous position and velocity, signed Q16.16.
//   Output channel (o_valid/i_ready) returns exactly one result per request,
//   in order: collided and rewound flags, new velocity, rewind fraction
//   (Q1.16, 65536 = no rewind) and new position.
//   Config port writes one register per cycle when i_cfg_we is high
//   (index order: origin x/y, normal x/y, contact margin, restitution);
//   write only while no request is in flight.
//   From input accept to output valid a request passes the dot products in
//   the front, one queue write, then the back pipeline, whose length is
//   set by the 16-step restoring divider that forms the rewind fraction
//   (one quotient bit per stage).
//   Throughput is one request per cycle while the receiver does not stall.
//   When the receiver stalls, the back pipeline holds; the front keeps
//   draining into an 8-entry queue and drops o_ready once its in-flight
//   plus queued count reaches 8.
//   Reset (synchronous, active low) empties the pipeline and queue and
//   sets config to origin 0, normal (0, 1.0), margin 0, restitution 1.0.
`default_nettype none
module plane_collision_response (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcr_pkg::IDX_W-1:0]         i_cfg_idx,
    input  wire logic [pcr_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [pcr_pkg::POS_W-1:0]  i_pos_x,
    input  wire logic signed [pcr_pkg::POS_W-1:0]  i_pos_y,
    input  wire logic signed [pcr_pkg::POS_W-1:0]  i_prev_x,
    input  wire logic signed [pcr_pkg::POS_W-1:0]  i_prev_y,
    input  wire logic signed [pcr_pkg::POS_W-1:0]  i_vel_x,
    input  wire logic signed [pcr_pkg::POS_W-1:0]  i_vel_y,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_collided,
    output logic                                   o_rewound,
    output logic signed [pcr_pkg::POS_W-1:0]       o_new_vel_x,
    output logic signed [pcr_pkg::POS_W-1:0]       o_new_vel_y,
    output logic [pcr_pkg::T_W-1:0]                o_rewind_fraction,
    output logic signed [pcr_pkg::POS_W-1:0]       o_new_pos_x,
    output logic signed [pcr_pkg::POS_W-1:0]       o_new_pos_y
);

    pcr_pkg::t_cfg  r_cfg;
    logic           push, pop, nempty;
    pcr_pkg::t_job  push_job, pop_job;

    // config registers; bits above each register's width are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.normal_x    <= '0;
            r_cfg.normal_y    <= pcr_pkg::N_W'(1 << pcr_pkg::FRAC_BITS);
            r_cfg.margin      <= '0;
            r_cfg.restitution <= pcr_pkg::KR_W'(1 << pcr_pkg::FRAC_BITS);
        end else if (i_cfg_we) begin
            unique case (pcr_pkg::t_cfg_idx'(i_cfg_idx))
                pcr_pkg::CFG_ORIGIN_X: begin
                    r_cfg.origin_x <= $signed(i_cfg_data[pcr_pkg::POS_W-1:0]);
                end
                pcr_pkg::CFG_ORIGIN_Y: begin
                    r_cfg.origin_y <= $signed(i_cfg_data[pcr_pkg::POS_W-1:0]);
                end
                pcr_pkg::CFG_NORMAL_X: begin
                    r_cfg.normal_x <= $signed(i_cfg_data[pcr_pkg::N_W-1:0]);
                end
                pcr_pkg::CFG_NORMAL_Y: begin
                    r_cfg.normal_y <= $signed(i_cfg_data[pcr_pkg::N_W-1:0]);
                end
                pcr_pkg::CFG_MARGIN: begin
                    r_cfg.margin <= i_cfg_data[pcr_pkg::MRG_W-1:0];
                end
                pcr_pkg::CFG_RESTITUTION: begin
                    r_cfg.restitution <= i_cfg_data[pcr_pkg::KR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pcr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_pos_x  (i_pos_x),
        .i_pos_y  (i_pos_y),
        .i_prev_x (i_prev_x),
        .i_prev_y (i_prev_y),
        .i_vel_x  (i_vel_x),
        .i_vel_y  (i_vel_y),
        .i_pop    (pop),
        .o_push   (push),
        .o_job    (push_job)
    );

    pcr_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_job),
        .i_pop    (pop),
        .o_nempty (nempty),
        .o_data   (pop_job)
    );

    pcr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_job_valid       (nempty),
        .i_job             (pop_job),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_collided        (o_collided),
        .o_rewound         (o_rewound),
        .o_new_vel_x       (o_new_vel_x),
        .o_new_vel_y       (o_new_vel_y),
        .o_rewind_fraction (o_rewind_fraction),
        .o_new_pos_x       (o_new_pos_x),
        .o_new_pos_y       (o_new_pos_y)
    );

endmodule
`default_nettype wire

[tb/tb_plane_collision_response.sv]
// Testbench for plane_collision_response: directed table on two planes, then random particle requests.
// Depends on pcr_pkg and the plane_collision_response RTL; checks against a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_plane_collision_response;

    typedef struct {
        logic signed [31:0] px, py, qx, qy, vx, vy;
    } t_particle;

    typedef struct {
        logic               collided;
        logic               rewound;
        logic signed [31:0] vel_x, vel_y;
        logic [16:0]        frac;
        logic signed [31:0] pos_x, pos_y;
    } t_response;

    // Directed row: request plus an optional typed-in expected response.
    typedef struct {
        t_particle p;
        bit        has_exp;
        t_response r;
    } t_row;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY     = 25;
    localparam int N_RANDOM    = 1600;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [pcr_pkg::IDX_W-1:0] i_cfg_idx;
    logic [pcr_pkg::CFG_W-1:0] i_cfg_data;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [31:0] i_pos_x, i_pos_y, i_prev_x, i_prev_y, i_vel_x, i_vel_y;
    logic o_collided, o_rewound;
    logic signed [31:0] o_new_vel_x, o_new_vel_y, o_new_pos_x, o_new_pos_y;
    logic [pcr_pkg::T_W-1:0] o_rewind_fraction;

    plane_collision_response i_dut (.*);

    // Predictor copy of the plane registers.
    logic signed [31:0] pl_ox, pl_oy;
    logic signed [17:0] pl_nx, pl_ny;
    logic [30:0]        pl_margin;
    logic [17:0]        pl_kr;

    t_response expected_q[$];
    int  n_errors;
    int  cycles;
    bit  quiet;        // no idling on either side near the end
    bit  sink_hold;    // unused; stall bursts are counted in stall_left

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
        n_errors++;
    endtask

    function automatic longint floor_div(input longint x);
        return x >>> pcr_pkg::FRAC_BITS;   // arithmetic shift is floor
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint rewind_ratio(input longint num, input longint den);
        longint an, ad, r, q;
        if (den == 0) return 65536;
        if (num == 0 || ((num < 0) != (den < 0))) return 0;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        if (an >= ad) return 65536;
        r = an;
        q = 0;
        for (int i = 0; i < pcr_pkg::FRAC_BITS; i++) begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= ad) begin
                r -= ad;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic t_response collide(input t_particle p);
        t_response o;
        longint px, py, qx, qy, vx, vy, ox, oy, nx, ny, eps, kr;
        longint pdist, vdot, s, vnx, vny, t;
        px = p.px; py = p.py; qx = p.qx; qy = p.qy; vx = p.vx; vy = p.vy;
        ox = pl_ox; oy = pl_oy; nx = pl_nx; ny = pl_ny;
        eps = longint'(pl_margin) <<< pcr_pkg::FRAC_BITS;
        kr = pl_kr;
        pdist = (px - ox) * nx + (py - oy) * ny;
        vdot = vx * nx + vy * ny;
        o.collided = (pdist < eps) && (vdot < 0);
        o.rewound = 0;
        o.vel_x = p.vx; o.vel_y = p.vy;
        o.pos_x = p.px; o.pos_y = p.py;
        t = 65536;
        if (o.collided) begin
            s = floor_div(vdot);
            vnx = floor_div(s * nx);
            vny = floor_div(s * ny);
            o.vel_x = 32'(clamp32((vx - vnx) - floor_div(kr * vnx)));
            o.vel_y = 32'(clamp32((vy - vny) - floor_div(kr * vny)));
            if (pdist <= 0) begin
                o.rewound = 1;
                t = rewind_ratio((ox - qx) * nx + (oy - qy) * ny,
                                 (px - qx) * nx + (py - qy) * ny);
                o.pos_x = 32'(clamp32(qx + floor_div(t * (px - qx))));
                o.pos_y = 32'(clamp32(qy + floor_div(t * (py - qy))));
            end
        end
        o.frac = t[16:0];
        return o;
    endfunction

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[plane_collision_response] ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, checks each accepted response.
    int stall_left;
    always @(posedge i_clk) begin
        t_response w;
        if (!i_rst_n) begin
            i_ready <= 0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $display("mismatch: response with nothing expected (t=%0t)", $time);
                    n_errors++;
                end else begin
                    w = expected_q.pop_front();
                    if (o_collided !== w.collided) report("collided", o_collided, w.collided);
                    if (o_rewound !== w.rewound) report("rewound", o_rewound, w.rewound);
                    if (o_new_vel_x !== w.vel_x) report("new_vel_x", o_new_vel_x, w.vel_x);
                    if (o_new_vel_y !== w.vel_y) report("new_vel_y", o_new_vel_y, w.vel_y);
                    if (o_rewind_fraction !== w.frac)
                        report("rewind_fraction", o_rewind_fraction, w.frac);
                    if (o_new_pos_x !== w.pos_x) report("new_pos_x", o_new_pos_x, w.pos_x);
                    if (o_new_pos_y !== w.pos_y) report("new_pos_y", o_new_pos_y, w.pos_y);
                end
            end
            if (stall_left > 0) stall_left--;
            else if (!quiet && $urandom_range(0, 19) == 0) stall_left = $urandom_range(1, 17);
            i_ready <= (stall_left == 0);
        end
    end

    // One register write; the write enable is then dropped and the predictor copy updated.
    task automatic write_reg(input pcr_pkg::t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            pcr_pkg::CFG_ORIGIN_X:    pl_ox = val;
            pcr_pkg::CFG_ORIGIN_Y:    pl_oy = val;
            pcr_pkg::CFG_NORMAL_X:    pl_nx = val[17:0];
            pcr_pkg::CFG_NORMAL_Y:    pl_ny = val[17:0];
            pcr_pkg::CFG_MARGIN:      pl_margin = val[30:0];
            pcr_pkg::CFG_RESTITUTION: pl_kr = val[17:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // One request: optional idle burst, then hold valid until accepted.
    // Valid stays high after acceptance; the next request or drain replaces it.
    task automatic send(input t_particle p, input bit has_exp, input t_response r);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_pos_x <= p.px; i_pos_y <= p.py;
        i_prev_x <= p.qx; i_prev_y <= p.qy;
        i_vel_x <= p.vx; i_vel_y <= p.vy;
        expected_q.push_back(has_exp ? r : collide(p));
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [31:0] rnd_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    // Random particle: mostly small coordinates, some full-range or extreme ones.
    function automatic t_particle rnd_particle();
        t_particle p;
        int m;
        m = $urandom_range(0, 9);
        p.px = rnd_coord(m < 2 ? 0 : (m == 9 ? 2 : 1));
        p.py = rnd_coord(m < 2 ? 0 : (m == 8 ? 2 : 1));
        p.qx = rnd_coord(m < 2 ? 0 : 1);
        p.qy = rnd_coord(m < 2 ? 0 : 1);
        p.vx = rnd_coord(m < 3 ? 0 : (m == 7 ? 2 : 1));
        p.vy = rnd_coord(m < 3 ? 0 : (m == 6 ? 2 : 1));
        if (m == 5) begin
            p.qx = p.px;
            p.qy = p.py;   // zero denominator
        end
        return p;
    endfunction

    task automatic rnd_plane();
        int k;
        k = $urandom_range(0, 5);
        write_reg(pcr_pkg::CFG_ORIGIN_X, k == 0 ? 32'h80000000 : rnd_coord(1));
        write_reg(pcr_pkg::CFG_ORIGIN_Y, k == 1 ? 32'h7fffffff : rnd_coord(1));
        case (k)
            0: begin
                write_reg(pcr_pkg::CFG_NORMAL_X, 18'h10000);
                write_reg(pcr_pkg::CFG_NORMAL_Y, 0);
            end
            1: begin
                write_reg(pcr_pkg::CFG_NORMAL_X, 18'h30000);
                write_reg(pcr_pkg::CFG_NORMAL_Y, 0);
            end
            2: begin
                write_reg(pcr_pkg::CFG_NORMAL_X, 46341);
                write_reg(pcr_pkg::CFG_NORMAL_Y, 46341);
            end
            default: begin
                write_reg(pcr_pkg::CFG_NORMAL_X, $urandom());
                write_reg(pcr_pkg::CFG_NORMAL_Y, $urandom());
            end
        endcase
        write_reg(pcr_pkg::CFG_MARGIN, k == 3 ? 32'h7fffffff : $urandom_range(0, 65536 * 4));
        write_reg(pcr_pkg::CFG_RESTITUTION, k == 4 ? 131072 : (k == 5 ? 0 : $urandom()));
    endtask

    t_row rows[$];

    function automatic t_row mk(input logic signed [31:0] px, py, qx, qy, vx, vy);
        t_row r;
        r.p = '{px, py, qx, qy, vx, vy};
        r.has_exp = 0;
        r.r = '{0, 0, vx, vy, 17'h10000, px, py};
        return r;
    endfunction

    initial begin
        t_row r;
        t_particle p;
        t_response none;
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 0;
        i_pos_x = 0; i_pos_y = 0; i_prev_x = 0; i_prev_y = 0; i_vel_x = 0; i_vel_y = 0;
        n_errors = 0; cycles = 0; quiet = 0;
        pl_ox = 0; pl_oy = 0; pl_nx = 0; pl_ny = 18'h10000; pl_margin = 0; pl_kr = 18'h10000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Reset plane is the floor y = 0 with margin 0, restitution 1.
        r = mk(0, 32'sh10000, 0, 32'sh20000, 0, -32'sh10000); r.has_exp = 1; rows.push_back(r);
        r = mk(0, 0, 0, 32'sh10000, 0, 32'sh10000); r.has_exp = 1; rows.push_back(r);
        // Crossed floor, halfway rewind: t = 0.5.
        r = mk(0, -32'sh10000, 0, 32'sh10000, 32'sh10000, -32'sh10000); r.has_exp = 1;
        r.r = '{1, 1, 32'sh10000, 32'sh10000, 17'h08000, 0, 0}; rows.push_back(r);
        // Zero denominator: previous equals current, just below the floor.
        r = mk(5, -1, 5, -1, 0, -32'sh10000); r.has_exp = 1;
        r.r = '{1, 1, 0, 32'sh10000, 17'h10000, 5, -1}; rows.push_back(r);
        // Negative ratio: previous also below plane -> t = 0, pos = prev.
        r = mk(0, -32'sh30000, 7, -32'sh10000, 0, -32'sh10000); r.has_exp = 1;
        r.r = '{1, 1, 0, 32'sh10000, 17'h0, 7, -32'sh10000}; rows.push_back(r);
        rows.push_back(mk(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                          32'sh7fffffff, 32'sh80000000));
        rows.push_back(mk(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh80000000, 32'sh80000000));
        rows.push_back(mk(-1, -1, -1, -1, -1, -1));
        rows.push_back(mk(0, -3, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
        rows.push_back(mk(0, -32'sh10000, 0, -32'sh8000, 0, -1));
        foreach (rows[i]) send(rows[i].p, rows[i].has_exp, rows[i].r);
        drain();

        // Extreme plane: slanted wall, full margin, restitution 2.
        write_reg(pcr_pkg::CFG_ORIGIN_X, 32'h7fffffff);
        write_reg(pcr_pkg::CFG_ORIGIN_Y, 32'h80000000);
        write_reg(pcr_pkg::CFG_NORMAL_X, 18'h30000);
        write_reg(pcr_pkg::CFG_NORMAL_Y, 18'h10000);
        write_reg(pcr_pkg::CFG_MARGIN, 32'h7fffffff);
        write_reg(pcr_pkg::CFG_RESTITUTION, 131072);
        foreach (rows[i]) send(rows[i].p, 0, none);
        // Hold off until the pipeline is empty, then a new plane.
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            rnd_plane();
            if (phase == 7) quiet = 1;
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                p = rnd_particle();
                send(p, 0, none);
            end
            drain();
        end

        if (n_errors == 0)
            $display("[plane_collision_response] OK");
        else
            $display("[plane_collision_response] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
